FILE: rtl/sliding_window_mean_median_assert.svh
// Assertion macros shared by the checker of the window statistics block.
`ifndef SLIDING_WINDOW_MEAN_MEDIAN_ASSERT_SVH
`define SLIDING_WINDOW_MEAN_MEDIAN_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SWMM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed: lbl");

// next-cycle implication
`define SWMM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed: lbl");

`endif

FILE: rtl/swmm_pkg.sv
// Package: sizes, field widths and cell control for the window statistics block.
`timescale 1ns / 1ps
package swmm_pkg;
  localparam int SWMM_WINDOW      = 300;
  localparam int SWMM_SAMPLE_BITS = 24;
  localparam int IN_SAMPLE_W      = 24;
  localparam int COUNT_W          = 9;
  localparam int MEAN_W           = 24;
  localparam int MED_W            = 25;

  typedef struct packed {
    logic clr;      // empty every cell
    logic upd;      // delete/insert step
    logic del_en;   // a held value leaves in this step
    logic load_sh;  // copy keys into the shadow line
    logic shift;    // move shadow line one cell toward cell 0
  } cell_ctrl_t;
endpackage

FILE: rtl/swmm_if.sv
// Valid/ready channel interfaces for input words and result words.
`timescale 1ns / 1ps
interface swmm_in_if import swmm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   clear;
  logic [IN_SAMPLE_W-1:0] sample_us;
  modport source (output valid, clear, sample_us, input ready);
  modport sink   (input valid, clear, sample_us, output ready);
endinterface

interface swmm_out_if import swmm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] count;
  logic [MEAN_W-1:0]  mean_us;
  logic [MED_W-1:0]   median_doubled_us;
  modport source (output valid, count, mean_us, median_doubled_us, input ready);
  modport sink   (input valid, count, mean_us, median_doubled_us, output ready);
endinterface

FILE: rtl/swmm_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module swmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/swmm_cell.sv
// One cell of the sorted chain: holds a key and a shadow copy used to read out the median.
`timescale 1ns / 1ps
module swmm_cell import swmm_pkg::*; #(
  parameter int KW = 25
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cell_ctrl_t    ctrl,
  input  logic [KW-1:0] old_key,
  input  logic [KW-1:0] new_key,
  input  logic          prev_ok,
  input  logic [KW-1:0] key_prev,
  input  logic          d_prev,
  input  logic [KW-1:0] key_next,
  input  logic [KW-1:0] sh_next,
  output logic [KW-1:0] key,
  output logic          d_self,
  output logic [KW-1:0] sh
);
  localparam logic [KW-1:0] INF = {1'b1, {(KW-1){1'b0}}};

  logic [KW-1:0] key_r, key_nxt, sh_r, sh_nxt;
  logic [KW-1:0] a_prev, a_self;

  // d_self: this cell sits at or above the slot being deleted
  assign d_self = ctrl.del_en && (key_r >= old_key);
  // neighbors as they stand after the delete
  assign a_prev = d_prev ? key_r : key_prev;
  assign a_self = d_self ? key_next : key_r;

  always_comb begin
    key_nxt = key_r;
    if (ctrl.clr) begin
      key_nxt = INF;
    end else if (ctrl.upd) begin
      if (prev_ok && (a_prev >= new_key)) begin
        key_nxt = a_prev;
      end else if (a_self >= new_key) begin
        key_nxt = new_key;
      end else begin
        key_nxt = a_self;
      end
    end
  end

  always_comb begin
    sh_nxt = sh_r;
    if (ctrl.load_sh) begin
      sh_nxt = key_r;
    end else if (ctrl.shift) begin
      sh_nxt = sh_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= INF;
    end else begin
      key_r <= key_nxt;
    end
    sh_r <= sh_nxt;
  end

  assign key = key_r;
  assign sh  = sh_r;
endmodule

FILE: rtl/swmm_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module swmm_div #(
  parameter int NW = 33,
  parameter int DW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);
  localparam int IW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [IW-1:0] it_r, it_nxt;
  logic [DW:0]   trial;
  logic          take;

  assign trial = {rem_r, q_r[NW-1]};
  assign take  = trial >= {1'b0, divisor};

  always_comb begin
    q_nxt   = q_r;
    rem_nxt = rem_r;
    it_nxt  = it_r;
    if (start) begin
      q_nxt   = dividend;
      rem_nxt = '0;
      it_nxt  = IW'(NW);
    end else if (it_r != '0) begin
      rem_nxt = take ? DW'(trial - {1'b0, divisor}) : DW'(trial);
      q_nxt   = {q_r[NW-2:0], take};
      it_nxt  = it_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_r <= '0;
    end else begin
      it_r <= it_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = (it_r == '0);
  assign quotient = q_r;
endmodule

FILE: rtl/sliding_window_mean_median.sv
// Sliding-window count, mean and doubled median over the last WINDOW frame-time samples.
//
// Each input word either clears the window or appends one sample; every word yields one
// result word. Samples live in a ring RAM and, as keys, in a sorted chain of WINDOW cells
// that deletes the oldest value and inserts the new one in a single step. The median is
// read by copying the chain into a shadow line and shifting it (count-1)/2 cells toward
// cell 0, while a restoring divider forms the mean one bit a cycle. After a word is
// accepted the block steps through read, update and prepare states, then waits in a
// calculate state until both the divider and the shadow shift are done; the result then
// enters the output register (an empty window skips the calculate state). A result the
// receiver has not taken holds the next one back. The next word is accepted in the cycle
// after the current result enters the output register.
`timescale 1ns / 1ps
module sliding_window_mean_median import swmm_pkg::*; #(
  parameter int WINDOW      = SWMM_WINDOW,
  parameter int SAMPLE_BITS = SWMM_SAMPLE_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  swmm_in_if.sink   in_ch,
  swmm_out_if.source out_ch
);
  localparam int CW   = $clog2(WINDOW + 1);
  localparam int PW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUMW = SAMPLE_BITS + CW;
  localparam int KW   = SAMPLE_BITS + 1;
  localparam logic [KW-1:0] INF = {1'b1, {SAMPLE_BITS{1'b0}}};

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_PREP = 3'd3;
  localparam logic [2:0] S_CALC = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]             st_r, st_nxt;
  logic                   clr_r;
  logic [SAMPLE_BITS-1:0] smp_r;
  logic [PW-1:0]          pos_r, pos_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [SUMW-1:0]        sum_r, sum_nxt;
  logic [CW-1:0]          sh_r, sh_nxt;
  logic                   ov_r, ov_nxt;
  logic [COUNT_W-1:0]     ocnt_r;
  logic [MEAN_W-1:0]      omean_r;
  logic [MED_W-1:0]       omed_r;

  logic [31:0]            in_wide;
  logic [SAMPLE_BITS-1:0] in_smp;
  logic                   accept, full, div_done, div_start, out_load;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic [PW-1:0]          waddr;
  logic [PW:0]            pos_sum;
  logic [SUMW-1:0]        quotient;
  cell_ctrl_t             ctrl;

  logic [KW-1:0] key_w [0:WINDOW];
  logic [KW-1:0] sh_w  [0:WINDOW];
  logic          d_w   [0:WINDOW-1];

  assign in_wide  = 32'(in_ch.sample_us);
  assign in_smp   = in_wide[SAMPLE_BITS-1:0];
  assign in_ch.ready = (st_r == S_IDLE);
  assign accept   = in_ch.valid && in_ch.ready;
  assign full     = (cnt_r == CW'(WINDOW));
  assign pos_sum  = {1'b0, pos_r} + (PW + 1)'(cnt_r);
  assign waddr    = full ? pos_r :
                    ((pos_sum >= (PW + 1)'(WINDOW)) ? PW'(pos_sum - (PW + 1)'(WINDOW))
                                                    : pos_sum[PW-1:0]);
  assign div_start = (st_r == S_PREP);
  assign out_load  = (st_r == S_OUT) && (!ov_r || out_ch.ready);

  swmm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW), .AW(PW)) u_ram (
    .clk   (clk),
    .we    ((st_r == S_UPD) && !clr_r),
    .waddr (waddr),
    .wdata (smp_r),
    .raddr (pos_r),
    .rdata (ram_rdata)
  );

  swmm_div #(.NW(SUMW), .DW(CW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    ctrl         = '0;
    ctrl.clr     = (st_r == S_UPD) && clr_r;
    ctrl.upd     = (st_r == S_UPD) && !clr_r;
    ctrl.del_en  = (st_r == S_UPD) && !clr_r && full;
    ctrl.load_sh = (st_r == S_PREP);
    ctrl.shift   = (st_r == S_CALC) && (sh_r != '0);
  end

  assign key_w[WINDOW] = INF;
  assign sh_w[WINDOW]  = INF;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    swmm_cell #(.KW(KW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .old_key  ({1'b0, ram_rdata}),
      .new_key  ({1'b0, smp_r}),
      .prev_ok  (i != 0),
      .key_prev ((i == 0) ? key_w[0] : key_w[(i == 0) ? 0 : i - 1]),
      .d_prev   ((i == 0) ? 1'b0 : d_w[(i == 0) ? 0 : i - 1]),
      .key_next (key_w[i + 1]),
      .sh_next  (sh_w[i + 1]),
      .key      (key_w[i]),
      .d_self   (d_w[i]),
      .sh       (sh_w[i])
    );
  end

  always_comb begin
    st_nxt  = st_r;
    pos_nxt = pos_r;
    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    sh_nxt  = sh_r;
    ov_nxt  = ov_r && !out_ch.ready;
    case (st_r)
      S_IDLE: begin
        if (accept) st_nxt = S_READ;
      end
      S_READ: st_nxt = S_UPD;
      S_UPD: begin
        if (clr_r) begin
          pos_nxt = '0;
          cnt_nxt = '0;
          sum_nxt = '0;
        end else if (full) begin
          sum_nxt = sum_r - SUMW'(ram_rdata) + SUMW'(smp_r);
          pos_nxt = (pos_r == PW'(WINDOW - 1)) ? '0 : pos_r + 1'b1;
        end else begin
          sum_nxt = sum_r + SUMW'(smp_r);
          cnt_nxt = cnt_r + 1'b1;
        end
        st_nxt = S_PREP;
      end
      S_PREP: begin
        sh_nxt = (cnt_r == '0) ? '0 : ((cnt_r - 1'b1) >> 1);
        st_nxt = (cnt_r == '0) ? S_OUT : S_CALC;
      end
      S_CALC: begin
        if (sh_r != '0) sh_nxt = sh_r - 1'b1;
        if ((sh_r == '0) && div_done) st_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          ov_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  logic [63:0]          q64;
  logic [SAMPLE_BITS:0] med_val;
  logic [63:0]          med64;
  logic [63:0]          cnt64;

  assign q64     = 64'(quotient);
  assign med_val = cnt_r[0] ? {sh_w[0][SAMPLE_BITS-1:0], 1'b0}
                            : ({1'b0, sh_w[0][SAMPLE_BITS-1:0]} +
                               {1'b0, sh_w[1][SAMPLE_BITS-1:0]});
  assign med64   = 64'(med_val);
  assign cnt64   = 64'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      pos_r <= '0;
      cnt_r <= '0;
      sum_r <= '0;
      sh_r  <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      pos_r <= pos_nxt;
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
      sh_r  <= sh_nxt;
      ov_r  <= ov_nxt;
    end
    if (accept) begin
      clr_r <= in_ch.clear;
      smp_r <= in_smp;
    end
    if (out_load) begin
      ocnt_r  <= cnt64[COUNT_W-1:0];
      omean_r <= (cnt_r == '0) ? '0 : q64[MEAN_W-1:0];
      omed_r  <= (cnt_r == '0) ? '0 : med64[MED_W-1:0];
    end
  end

  assign out_ch.valid             = ov_r;
  assign out_ch.count             = ocnt_r;
  assign out_ch.mean_us           = omean_r;
  assign out_ch.median_doubled_us = omed_r;
endmodule

FILE: rtl/swmm_checker.sv
// Port-level checker for the window statistics block, bound to the top level.
`timescale 1ns / 1ps
`include "sliding_window_mean_median_assert.svh"
module swmm_checker import swmm_pkg::*; #(
  parameter int WINDOW = SWMM_WINDOW
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COUNT_W-1:0] out_count,
  input logic [MEAN_W-1:0]  out_mean,
  input logic [MED_W-1:0]   out_med
);
  `SWMM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `SWMM_ASSERT_NOW(a_count_max, out_valid, 32'(out_count) <= 32'(WINDOW))
  `SWMM_ASSERT_NOW(a_empty_zero, out_valid && (out_count == '0), (out_mean == '0) && (out_med == '0))
  `SWMM_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
endmodule

bind sliding_window_mean_median swmm_checker #(.WINDOW(WINDOW)) u_swmm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_count (out_ch.count),
  .out_mean  (out_ch.mean_us),
  .out_med   (out_ch.median_doubled_us)
);

FILE: bench/testbench.sv
// Testbench for the sliding-window mean and median block: random words, running prediction.
`timescale 1ns / 1ps
module testbench;
  import swmm_pkg::*;

  typedef struct packed {
    logic                   clear;
    logic [IN_SAMPLE_W-1:0] sample_us;
  } frame_word_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [MEAN_W-1:0]  mean_us;
    logic [MED_W-1:0]   median_doubled_us;
  } stats_word_t;

  localparam int WIN = SWMM_WINDOW;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk;
  logic rst_n;

  swmm_in_if  in_ch ();
  swmm_out_if out_ch ();

  sliding_window_mean_median u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  frame_word_t pending_words[$];
  stats_word_t expected_stats[$];

  // predictor copy of the window
  logic [IN_SAMPLE_W-1:0] win_samples[WIN];
  int unsigned            win_oldest;
  int unsigned            win_held;
  logic [63:0]            win_sum;

  int  errors;
  int  cycles;
  bit  quiet;        // no idling near the end
  bit  send_pause;   // sender waits until results drain
  bit  long_hold;    // receiver holds off for a long stretch
  bit  in_taken;     // input word accepted at the last rising edge
  int  hold_left;
  int  send_gap;
  int  recv_gap;
  int  accepted;

  function automatic stats_word_t window_stats(frame_word_t w);
    stats_word_t r;
    logic [IN_SAMPLE_W-1:0] sorted[$];
    int unsigned pos;
    int unsigned mid;
    logic [63:0] med;
    if (w.clear) begin
      win_held = 0;
      win_oldest = 0;
      win_sum = 0;
    end else if (win_held >= WIN) begin
      pos = win_oldest % WIN;
      win_sum = win_sum - win_samples[pos] + w.sample_us;
      win_samples[pos] = w.sample_us;
      win_oldest = (pos + 1) % WIN;
    end else begin
      pos = (win_oldest + win_held) % WIN;
      win_samples[pos] = w.sample_us;
      win_sum += w.sample_us;
      win_held++;
    end
    r = '0;
    r.count = win_held[COUNT_W-1:0];
    if (win_held != 0) begin
      r.mean_us = MEAN_W'(win_sum / win_held);
      for (int i = 0; i < win_held; i++) sorted = {sorted, win_samples[(win_oldest + i) % WIN]};
      sorted.sort();
      mid = win_held / 2;
      if (win_held % 2) med = 64'(sorted[mid]) * 2;
      else med = 64'(sorted[mid-1]) + 64'(sorted[mid]);
      r.median_doubled_us = MED_W'(med);
    end
    return r;
  endfunction

  function automatic frame_word_t sample_word(logic [IN_SAMPLE_W-1:0] s);
    frame_word_t w;
    w.clear = 1'b0;
    w.sample_us = s;
    return w;
  endfunction

  function automatic void add_word(frame_word_t w);
    pending_words = {pending_words, w};
  endfunction

  function automatic logic [IN_SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return IN_SAMPLE_W'($urandom_range(0, 40));
      3: return IN_SAMPLE_W'($urandom_range(16000, 17000));
      default: return IN_SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // driver
  always @(negedge clk) begin
    frame_word_t nw;
    stats_word_t ns;
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.clear     <= 1'b0;
      in_ch.sample_us <= '0;
    end else begin
      if (in_taken) accepted++;
      if (send_gap > 0) send_gap--;
      if (in_ch.valid && !in_taken) begin
        // hold the offered word
      end else if (send_pause && expected_stats.size() != 0) begin
        in_ch.valid <= 1'b0;
      end else if (pending_words.size() == 0 || send_gap > 0) begin
        in_ch.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 19) == 0) begin
        send_gap = $urandom_range(1, 16);
        in_ch.valid <= 1'b0;
      end else begin
        nw = pending_words.pop_front();
        ns = window_stats(nw);
        expected_stats = {expected_stats, ns};
        in_ch.clear     <= nw.clear;
        in_ch.sample_us <= nw.sample_us;
        in_ch.valid     <= 1'b1;
      end
    end
  end

  // receiver readiness, counted in its own process
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (long_hold && hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 19) == 0) begin
      recv_gap = $urandom_range(1, 16);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    stats_word_t e;
    cycles++;
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_stats.size() == 0) begin
        $error("result word with no expectation");
        errors++;
      end else begin
        e = expected_stats.pop_front();
        if (out_ch.count !== e.count) begin
          $error("count: expected %0d actual %0d", e.count, out_ch.count);
          errors++;
        end
        if (out_ch.mean_us !== e.mean_us) begin
          $error("mean_us: expected %0d actual %0d", e.mean_us, out_ch.mean_us);
          errors++;
        end
        if (out_ch.median_doubled_us !== e.median_doubled_us) begin
          $error("median_doubled_us: expected %0d actual %0d",
                 e.median_doubled_us, out_ch.median_doubled_us);
          errors++;
        end
      end
    end
  end

  initial begin
    frame_word_t w;
    int n;
    errors = 0; cycles = 0; accepted = 0;
    quiet = 0; send_pause = 0; long_hold = 0; hold_left = 0;
    send_gap = 0; recv_gap = 0; in_taken = 0;
    win_oldest = 0; win_held = 0; win_sum = 0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty window, extremes, clear on empty, clear with sample bits set
    w.clear = 1'b1; w.sample_us = '1; add_word(w);
    add_word(sample_word('1));
    add_word(sample_word('0));
    add_word(sample_word('1));
    add_word(sample_word('1));
    add_word(sample_word(24'h000001));
    w.clear = 1'b1; w.sample_us = 24'h5A5A5A; add_word(w);
    w.clear = 1'b1; w.sample_us = '0; add_word(w);
    add_word(sample_word(24'd7));
    add_word(sample_word(24'd3));
    add_word(sample_word(24'hAAAAAA));
    add_word(sample_word(24'h555555));
    w.clear = 1'b1; w.sample_us = '0; add_word(w);
    // fill past full with max values to wrap the ring and stress the sum
    for (int i = 0; i < WIN + 20; i++) add_word(sample_word('1));
    wait (pending_words.size() == 0);

    // sender pause until drained
    send_pause = 1;
    wait (expected_stats.size() == 0);
    send_pause = 0;

    // long receiver hold-off while the sender keeps offering
    for (int i = 0; i < 40; i++) add_word(sample_word(rand_sample()));
    hold_left = 3000;
    long_hold = 1;
    wait (pending_words.size() == 0 && hold_left == 0);
    long_hold = 0;

    // random: mostly appends of random content, runs of varied length between clears
    n = 0;
    while (n < 1330) begin
      if ($urandom_range(0, 99) < 2) begin
        w.clear = 1'b1; w.sample_us = IN_SAMPLE_W'($urandom);
      end else begin
        w = sample_word(rand_sample());
      end
      add_word(w);
      n++;
      if (n == 1100) begin
        wait (pending_words.size() == 0);
        quiet = 1;
      end
      if (pending_words.size() > 64) wait (pending_words.size() < 16);
    end

    wait (pending_words.size() == 0 && !in_ch.valid);
    wait (expected_stats.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_stats.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
